[hw/rtl/rbt_pkg.sv]
// ============================================================================
// rbt_pkg
// Shared widths, constants, register indexes and the per-pixel flag bundle
// of the radiance to brightness temperature pipeline.
// ============================================================================
package rbt_pkg;

   localparam int COUNT_BITS     = 10;
   localparam int LOG_ITERATIONS = 24;

   // Configuration port.
   localparam int CSR_DATA_W  = 63;
   localparam int CSR_INDEX_W = 3;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CALIB_OFFSET   = 3'd0,
      CSR_CALIB_SLOPE    = 3'd1,
      CSR_RADIANCE_SCALE = 3'd2,
      CSR_TEMP_SCALE     = 3'd3,
      CSR_BAND_ALPHA     = 3'd4,
      CSR_BAND_BETA      = 3'd5,
      CSR_NODATA_COUNT   = 3'd6,
      CSR_NODATA_OUT     = 3'd7
   } csr_index_type;

   localparam int CALIB_W    = 32;
   localparam int RSCALE_W   = 63;
   localparam int TS_W       = 40;
   localparam int ALPHA_W    = 32;
   localparam int BETA_W     = 32;
   localparam int NODATA_W   = 11;
   localparam int OUT_W      = 16;

   localparam int CMP_W  = (COUNT_BITS > NODATA_W) ? COUNT_BITS : NODATA_W;
   localparam int PROD_W = COUNT_BITS + CALIB_W + 1;
   localparam int RAD_W  = PROD_W + 1;

   // Base-2 logarithm unit.
   localparam int LOG_IN_W = 64;
   localparam int EXP_W    = 6;
   localparam int MANT_W   = 32;
   localparam int LOG_W    = EXP_W + LOG_ITERATIONS;
   localparam int LOG_LAT  = LOG_ITERATIONS + 3;

   // ln 2 as a 0.32 fraction.
   localparam logic [31:0] LN2_Q32 = 32'd2977044472;

   // Temperature division: quotient of temp_scale * 2^T_SHIFT by the log,
   // clamped at 2^62.
   localparam int T_SHIFT   = LOG_ITERATIONS + 8;
   localparam int T_Q_W     = 62;
   localparam int T_STEPS   = T_Q_W;
   localparam int T_SAT_SH  = T_Q_W - T_SHIFT;
   localparam int U_W       = T_Q_W + 1;

   // Alpha division: only a 16-bit quotient survives saturation.
   localparam int A_SHIFT   = 12;
   localparam int A_Q_W     = OUT_W;
   localparam int A_STEPS   = A_Q_W;
   localparam int A_LO_W    = A_Q_W - A_SHIFT;

   typedef struct packed {
      logic nodata;
      logic bad_rad;
      logic zero_log;
      logic sat_t;
      logic neg;
      logic ovf;
   } pix_flags_type;

endpackage

[hw/rtl/radiance_to_brightness_temp.sv]
// ============================================================================
// radiance_to_brightness_temp
// Raw pixel count to brightness temperature through calibration and an
// inverse Planck relation, fully pipelined.
// ============================================================================
// The block takes one pixel per clock while the output is not stalled and
// returns one result per pixel, in order. The depth is set by the squaring
// stages of the two logarithm units and by the bit-per-stage restoring
// dividers: 62 stages for the temperature quotient and 16 for the alpha
// correction. When rsp_ready is low with a result waiting, the whole
// pipeline holds; req_ready drops in that same cycle. Configuration registers
// must be written only while no pixel is in flight; the block does not enforce it.
module radiance_to_brightness_temp (
   input  logic                            clock,
   input  logic                            reset,

   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [rbt_pkg::COUNT_BITS-1:0]  req_raw_count,

   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [rbt_pkg::OUT_W-1:0]       rsp_temperature_kelvin,
   output logic                            rsp_is_invalid,
   output logic                            rsp_is_nodata,

   input  logic                            csr_write_enable,
   input  logic [rbt_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [rbt_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import rbt_pkg::*;

   // ---------------------------------------------------------------- config
   logic signed [CALIB_W-1:0] calib_offset_ff;
   logic signed [CALIB_W-1:0] calib_slope_ff;
   logic [RSCALE_W-1:0]       radiance_scale_ff;
   logic [TS_W-1:0]           temp_scale_ff;
   logic [ALPHA_W-1:0]        band_alpha_ff;
   logic signed [BETA_W-1:0]  band_beta_ff;
   logic [NODATA_W-1:0]       nodata_count_ff;
   logic [OUT_W-1:0]          nodata_out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         calib_offset_ff   <= '0;
         calib_slope_ff    <= '0;
         radiance_scale_ff <= '0;
         temp_scale_ff     <= '0;
         band_alpha_ff     <= ALPHA_W'(32'h4000_0000);
         band_beta_ff      <= '0;
         nodata_count_ff   <= NODATA_W'(1024);
         nodata_out_ff     <= '0;
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_CALIB_OFFSET: begin
               calib_offset_ff <= csr_write_data[CALIB_W-1:0];
            end
            CSR_CALIB_SLOPE: begin
               calib_slope_ff <= csr_write_data[CALIB_W-1:0];
            end
            CSR_RADIANCE_SCALE: begin
               radiance_scale_ff <= csr_write_data[RSCALE_W-1:0];
            end
            CSR_TEMP_SCALE: begin
               temp_scale_ff <= csr_write_data[TS_W-1:0];
            end
            CSR_BAND_ALPHA: begin
               band_alpha_ff <= csr_write_data[ALPHA_W-1:0];
            end
            CSR_BAND_BETA: begin
               band_beta_ff <= csr_write_data[BETA_W-1:0];
            end
            CSR_NODATA_COUNT: begin
               nodata_count_ff <= csr_write_data[NODATA_W-1:0];
            end
            CSR_NODATA_OUT: begin
               nodata_out_ff <= csr_write_data[OUT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // ---------------------------------------------------------------- flow
   logic rsp_valid_ff;
   logic en;

   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   // ---------------------------------------------------- calibration stages
   logic                     s1_valid_ff;
   logic [COUNT_BITS-1:0]    s1_count_ff;
   logic                     s2_valid_ff;
   logic                     s2_nodata_ff;
   logic signed [PROD_W-1:0] s2_prod_ff;
   logic                     s3_valid_ff;
   logic                     s3_nodata_ff;
   logic signed [RAD_W-1:0]  s3_rad_ff;
   logic signed [PROD_W-1:0] prod;

   assign prod = PROD_W'($signed({1'b0, s1_count_ff})) * PROD_W'(calib_slope_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_count_ff  <= req_raw_count;
         s2_nodata_ff <= CMP_W'(s1_count_ff) == CMP_W'(nodata_count_ff);
         s2_prod_ff   <= prod;
         s3_nodata_ff <= s2_nodata_ff;
         s3_rad_ff    <= RAD_W'(s2_prod_ff) + RAD_W'(calib_offset_ff);
      end
   end

   // ---------------------------------------------------------- logarithms
   // ln(x + 1) = ln(radiance_scale + R) - ln(R); both taken base 2 here.
   logic                 s3_bad_rad;
   logic [LOG_IN_W-1:0]  rad_mag;
   logic [LOG_IN_W-1:0]  n_a;
   logic [LOG_W-1:0]     log_a;
   logic [LOG_W-1:0]     log_b;
   pix_flags_type        s3_flags;

   assign s3_bad_rad = s3_rad_ff[RAD_W-1] || (s3_rad_ff == '0);
   assign rad_mag    = LOG_IN_W'($unsigned(s3_rad_ff));
   assign n_a        = {1'b0, radiance_scale_ff} + rad_mag;

   always_comb begin
      s3_flags         = '0;
      s3_flags.nodata  = s3_nodata_ff;
      s3_flags.bad_rad = s3_bad_rad;
   end

   rbt_log2 u_log_a (
      .clock   (clock),
      .en      (en),
      .n_in    (n_a),
      .log_out (log_a)
   );

   rbt_log2 u_log_b (
      .clock   (clock),
      .en      (en),
      .n_in    (rad_mag),
      .log_out (log_b)
   );

   logic          dl_valid_ff [1:LOG_LAT];
   pix_flags_type dl_flags_ff [1:LOG_LAT];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 1; k <= LOG_LAT; k++) begin
            dl_valid_ff[k] <= 1'b0;
         end
      end else if (en) begin
         dl_valid_ff[1] <= s3_valid_ff;
         for (int k = 2; k <= LOG_LAT; k++) begin
            dl_valid_ff[k] <= dl_valid_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dl_flags_ff[1] <= s3_flags;
         for (int k = 2; k <= LOG_LAT; k++) begin
            dl_flags_ff[k] <= dl_flags_ff[k-1];
         end
      end
   end

   // ------------------------------------------------- difference and ln 2
   logic                d_valid_ff;
   pix_flags_type       d_flags_ff;
   logic [LOG_W-1:0]    d_ff;
   logic                lq_valid_ff;
   pix_flags_type       lq_flags_ff;
   logic [LOG_W-1:0]    lq_ff;
   logic [LOG_W+31:0]   ln_prod;

   assign ln_prod = {32'b0, d_ff} * {{LOG_W{1'b0}}, LN2_Q32};

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff  <= 1'b0;
         lq_valid_ff <= 1'b0;
      end else if (en) begin
         d_valid_ff  <= dl_valid_ff[LOG_LAT];
         lq_valid_ff <= d_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_flags_ff  <= dl_flags_ff[LOG_LAT];
         d_ff        <= (log_a > log_b) ? log_a - log_b : '0;
         lq_flags_ff <= d_flags_ff;
         lq_ff       <= ln_prod[LOG_W+31:32];
      end
   end

   // ------------------------------------------------ temperature division
   // Stage 0 checks for a zero log or alpha and for a quotient at or above 2^62;
   // the quotient bits above 61 are then known to be zero, so the
   // remainder starts from the top of temp_scale.
   logic [LOG_W-1:0] ts_hi;
   pix_flags_type    z_flags;

   assign ts_hi = LOG_W'(temp_scale_ff >> T_SAT_SH);

   always_comb begin
      z_flags          = lq_flags_ff;
      z_flags.zero_log = (lq_ff == '0) || (band_alpha_ff == '0);
      z_flags.sat_t    = ts_hi >= lq_ff;
   end

   logic             tv_ff  [0:T_STEPS];
   pix_flags_type    tf_ff  [0:T_STEPS];
   logic [LOG_W-1:0] tr_ff  [0:T_STEPS];
   logic [T_Q_W-1:0] tq_ff  [0:T_STEPS];
   logic [LOG_W-1:0] tlq_ff [0:T_STEPS];
   logic [LOG_W-1:0] tr_in  [1:T_STEPS];
   logic [T_Q_W-1:0] tq_in  [1:T_STEPS];

   for (genvar k = 1; k <= T_STEPS; k++) begin : g_tdiv
      localparam int J = T_STEPS - k;
      logic           num_bit;
      logic [LOG_W:0] trial;
      logic [LOG_W:0] diff;
      logic           ge;

      if ((J >= T_SHIFT) && (J - T_SHIFT < TS_W)) begin : g_bit
         assign num_bit = temp_scale_ff[J-T_SHIFT];
      end else begin : g_zero
         assign num_bit = 1'b0;
      end

      assign trial    = {tr_ff[k-1], num_bit};
      assign diff     = trial - {1'b0, tlq_ff[k-1]};
      assign ge       = trial >= {1'b0, tlq_ff[k-1]};
      assign tr_in[k] = ge ? diff[LOG_W-1:0] : trial[LOG_W-1:0];
      assign tq_in[k] = {tq_ff[k-1][T_Q_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= T_STEPS; k++) begin
            tv_ff[k] <= 1'b0;
         end
      end else if (en) begin
         tv_ff[0] <= lq_valid_ff;
         for (int k = 1; k <= T_STEPS; k++) begin
            tv_ff[k] <= tv_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tf_ff[0]  <= z_flags;
         tr_ff[0]  <= ts_hi;
         tq_ff[0]  <= '0;
         tlq_ff[0] <= lq_ff;
         for (int k = 1; k <= T_STEPS; k++) begin
            tf_ff[k]  <= tf_ff[k-1];
            tr_ff[k]  <= tr_in[k];
            tq_ff[k]  <= tq_in[k];
            tlq_ff[k] <= tlq_ff[k-1];
         end
      end
   end

   // ------------------------------------------------------ beta correction
   logic             u_valid_ff;
   pix_flags_type    u_flags_ff;
   logic [U_W-1:0]   u_ff;
   logic [U_W-1:0]   t_val;
   logic [U_W:0]     u_full;
   pix_flags_type    u_flags;

   assign t_val  = tf_ff[T_STEPS].sat_t ? (U_W'(1) << T_Q_W) : {1'b0, tq_ff[T_STEPS]};
   assign u_full = {1'b0, t_val} - (U_W+1)'(band_beta_ff);

   always_comb begin
      u_flags     = tf_ff[T_STEPS];
      u_flags.neg = u_full[U_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         u_valid_ff <= 1'b0;
      end else if (en) begin
         u_valid_ff <= tv_ff[T_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         u_flags_ff <= u_flags;
         u_ff       <= u_full[U_W-1:0];
      end
   end

   // ------------------------------------------------------ alpha division
   // A quotient of 65536 or more saturates, which is u >= 16 * alpha; below
   // that only 16 quotient bits remain to be found.
   pix_flags_type v_flags;

   always_comb begin
      v_flags     = u_flags_ff;
      v_flags.ovf = u_ff >= (U_W'(band_alpha_ff) << A_LO_W);
   end

   logic               av_ff  [0:A_STEPS];
   pix_flags_type      af_ff  [0:A_STEPS];
   logic [ALPHA_W-1:0] ar_ff  [0:A_STEPS];
   logic [A_Q_W-1:0]   aq_ff  [0:A_STEPS];
   logic [A_LO_W-1:0]  alo_ff [0:A_STEPS];
   logic [ALPHA_W-1:0] ar_in  [1:A_STEPS];
   logic [A_Q_W-1:0]   aq_in  [1:A_STEPS];

   for (genvar k = 1; k <= A_STEPS; k++) begin : g_adiv
      localparam int J = A_STEPS - k;
      logic             num_bit;
      logic [ALPHA_W:0] trial;
      logic [ALPHA_W:0] diff;
      logic             ge;

      if (J >= A_SHIFT) begin : g_bit
         assign num_bit = alo_ff[k-1][J-A_SHIFT];
      end else begin : g_zero
         assign num_bit = 1'b0;
      end

      assign trial    = {ar_ff[k-1], num_bit};
      assign diff     = trial - {1'b0, band_alpha_ff};
      assign ge       = trial >= {1'b0, band_alpha_ff};
      assign ar_in[k] = ge ? diff[ALPHA_W-1:0] : trial[ALPHA_W-1:0];
      assign aq_in[k] = {aq_ff[k-1][A_Q_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= A_STEPS; k++) begin
            av_ff[k] <= 1'b0;
         end
      end else if (en) begin
         av_ff[0] <= u_valid_ff;
         for (int k = 1; k <= A_STEPS; k++) begin
            av_ff[k] <= av_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         af_ff[0]  <= v_flags;
         ar_ff[0]  <= u_ff[ALPHA_W+A_LO_W-1:A_LO_W];
         aq_ff[0]  <= '0;
         alo_ff[0] <= u_ff[A_LO_W-1:0];
         for (int k = 1; k <= A_STEPS; k++) begin
            af_ff[k]  <= af_ff[k-1];
            ar_ff[k]  <= ar_in[k];
            aq_ff[k]  <= aq_in[k];
            alo_ff[k] <= alo_ff[k-1];
         end
      end
   end

   // ------------------------------------------------------------- result
   pix_flags_type    fin_flags;
   logic [OUT_W-1:0] temp_in;
   logic             invalid_in;
   logic [OUT_W-1:0] temp_ff;
   logic             invalid_ff;
   logic             nodata_ff;

   assign fin_flags = af_ff[A_STEPS];

   always_comb begin
      temp_in    = aq_ff[A_STEPS];
      invalid_in = 1'b0;
      if (fin_flags.nodata) begin
         temp_in = nodata_out_ff;
      end else if (fin_flags.bad_rad || (!fin_flags.zero_log && fin_flags.neg)) begin
         temp_in    = '0;
         invalid_in = 1'b1;
      end else if (fin_flags.zero_log || fin_flags.ovf) begin
         temp_in    = '1;
         invalid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= av_ff[A_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         temp_ff    <= temp_in;
         invalid_ff <= invalid_in;
         nodata_ff  <= fin_flags.nodata;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_temperature_kelvin = temp_ff;
   assign rsp_is_invalid         = invalid_ff;
   assign rsp_is_nodata          = nodata_ff;

endmodule

[hw/rtl/rbt_log2.sv]
// ============================================================================
// rbt_log2
// Pipelined base-2 logarithm of a 64-bit integer: leading-one search,
// normalization to a 32-bit mantissa, then one squaring step per stage.
// ============================================================================
module rbt_log2 (
   input  logic                         clock,
   input  logic                         en,
   input  logic [rbt_pkg::LOG_IN_W-1:0] n_in,
   output logic [rbt_pkg::LOG_W-1:0]    log_out
);
   import rbt_pkg::*;

   localparam int SH_W = EXP_W + 1;

   function automatic logic [EXP_W-1:0] msb_index(input logic [LOG_IN_W-1:0] v);
      logic [EXP_W-1:0] idx;
      idx = '0;
      for (int i = 0; i < LOG_IN_W; i++) begin
         if (v[i]) begin
            idx = EXP_W'(i);
         end
      end
      return idx;
   endfunction

   logic [LOG_IN_W-1:0]        n1_ff;
   logic [LOG_IN_W-1:0]        n2_ff;
   logic [EXP_W-1:0]           e2_ff;
   logic [LOG_IN_W+MANT_W-1:0] norm_wide;

   logic [MANT_W-1:0]          m_ff    [0:LOG_ITERATIONS];
   logic [EXP_W-1:0]           e_ff    [0:LOG_ITERATIONS];
   logic [LOG_ITERATIONS-1:0]  frac_ff [1:LOG_ITERATIONS];

   logic [2*MANT_W-1:0]        sq      [1:LOG_ITERATIONS];
   logic [MANT_W-1:0]          m_in    [1:LOG_ITERATIONS];
   logic [LOG_ITERATIONS-1:0]  frac_in [1:LOG_ITERATIONS];

   // Bits e..e-31 of the operand, with zeros shifted in below.
   assign norm_wide = {n2_ff, {MANT_W{1'b0}}} >> (SH_W'(e2_ff) + SH_W'(1));

   for (genvar k = 1; k <= LOG_ITERATIONS; k++) begin : g_step
      assign sq[k]   = {{MANT_W{1'b0}}, m_ff[k-1]} * {{MANT_W{1'b0}}, m_ff[k-1]};
      assign m_in[k] = sq[k][2*MANT_W-1] ? sq[k][2*MANT_W-1:MANT_W]
                                         : sq[k][2*MANT_W-2:MANT_W-1];
      if (k == 1) begin : g_first
         assign frac_in[k] = LOG_ITERATIONS'(sq[k][2*MANT_W-1]);
      end else begin : g_rest
         assign frac_in[k] = {frac_ff[k-1][LOG_ITERATIONS-2:0], sq[k][2*MANT_W-1]};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         n1_ff   <= n_in;
         n2_ff   <= n1_ff;
         e2_ff   <= msb_index(n1_ff);
         m_ff[0] <= norm_wide[MANT_W-1:0];
         e_ff[0] <= e2_ff;
         for (int k = 1; k <= LOG_ITERATIONS; k++) begin
            m_ff[k]    <= m_in[k];
            e_ff[k]    <= e_ff[k-1];
            frac_ff[k] <= frac_in[k];
         end
      end
   end

   assign log_out = {e_ff[LOG_ITERATIONS], frac_ff[LOG_ITERATIONS]};

endmodule

[hw/rtl/rbt_checker.sv]
// ============================================================================
// rbt_checker
// Port-level checks on the brightness temperature pipeline, bound to the
// top level.
// ============================================================================
module rbt_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [rbt_pkg::OUT_W-1:0] rsp_temperature_kelvin,
   input logic                      rsp_is_invalid,
   input logic                      rsp_is_nodata
);

   // A result beat that is not taken stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp_valid dropped before the beat was taken");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_temperature_kelvin) &&
                                  $stable(rsp_is_invalid) && $stable(rsp_is_nodata))
      else $error("result payload changed while stalled");

   // The pipeline advances exactly when the output register can move.
   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("req_ready does not follow the output stall");

   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_is_nodata && rsp_is_invalid))
      else $error("a no-data pixel was flagged invalid");

   // Every invalid pixel is clamped to one end of the range.
   a_clamp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_invalid |->
         rsp_temperature_kelvin == 16'h0000 || rsp_temperature_kelvin == 16'hFFFF)
      else $error("invalid pixel carries an unclamped temperature");

endmodule

bind radiance_to_brightness_temp rbt_checker u_rbt_checker (.*);

[bench/tb_radiance_to_brightness_temp.sv]
// ============================================================================
// tb_radiance_to_brightness_temp
// Self-checking bench for the raw count to brightness temperature pipeline.
// ============================================================================
// Pixels are streamed through the block under several register settings and
// under random idling on both sides. A behavioral copy of the calibration,
// logarithm and division arithmetic predicts each result, and every result
// beat is compared field by field with the oldest prediction in order.
module tb_radiance_to_brightness_temp;
   import rbt_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [OUT_W-1:0] temp;
      logic             invalid;
      logic             nodata;
   } pixel_result_type;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic [COUNT_BITS-1:0]  req_raw_count;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [OUT_W-1:0]       rsp_temperature_kelvin;
   logic                   rsp_is_invalid;
   logic                   rsp_is_nodata;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;

   // Register copies used by the predictor.
   logic signed [CALIB_W-1:0] cfg_offset;
   logic signed [CALIB_W-1:0] cfg_slope;
   logic [RSCALE_W-1:0]       cfg_rscale;
   logic [TS_W-1:0]           cfg_tscale;
   logic [ALPHA_W-1:0]        cfg_alpha;
   logic signed [BETA_W-1:0]  cfg_beta;
   logic [NODATA_W-1:0]       cfg_nodata_count;
   logic [OUT_W-1:0]          cfg_nodata_out;

   pixel_result_type pending_temps[$];
   int mismatches;
   int pixels_sent;
   int results_seen;
   int send_idle_pct;
   int recv_idle_pct;
   int stall_cycles;

   radiance_to_brightness_temp uut (.*);

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   initial begin
      #5ms;
      $display("FAILED: results differ");
      $finish;
   end

   // ---------------------------------------------------------------- model
   function automatic logic [63:0] log2_fixed(logic [63:0] n);
      int e;
      logic [63:0] m;
      logic [63:0] sq;
      logic [63:0] frac;
      e = 0;
      frac = '0;
      while (e < 63 && (n >> (e + 1)) != 0) e++;
      m = (e >= 31) ? (n >> (e - 31)) : (n << (31 - e));
      for (int i = 0; i < LOG_ITERATIONS; i++) begin
         sq = m * m;
         frac = frac << 1;
         if (sq[63]) begin
            frac[0] = 1'b1;
            m = sq >> 32;
         end else begin
            m = sq >> 31;
         end
      end
      return (64'(e) << LOG_ITERATIONS) | frac;
   endfunction

   // floor(a * 2^sh / d), clamped at 2^62.
   function automatic logic [63:0] capped_quotient(logic [63:0] a, int sh,
                                                   logic [63:0] d);
      logic [63:0] r;
      logic [63:0] q;
      logic        bit_in;
      r = '0;
      q = '0;
      for (int i = 0; i < 64 + sh; i++) begin
         bit_in = (i < 64) ? a[63-i] : 1'b0;
         if (q >= 64'h2000_0000_0000_0000) return 64'h4000_0000_0000_0000;
         r = {r[62:0], bit_in};
         q = q << 1;
         if (r >= d) begin
            r = r - d;
            q[0] = 1'b1;
         end
      end
      return (q > 64'h4000_0000_0000_0000) ? 64'h4000_0000_0000_0000 : q;
   endfunction

   function automatic pixel_result_type brightness_temp(logic [COUNT_BITS-1:0] cnt);
      pixel_result_type res;
      longint     rad;
      longint     u;
      logic [63:0] la, lb, d, lq, t, q;
      res = '{temp: '0, invalid: 1'b0, nodata: 1'b0};
      if ({1'b0, cnt} == cfg_nodata_count) begin
         res.temp = cfg_nodata_out;
         res.nodata = 1'b1;
         return res;
      end
      rad = longint'(cfg_offset) + longint'({1'b0, cnt}) * longint'(cfg_slope);
      if (rad <= 0) begin
         res.invalid = 1'b1;
         return res;
      end
      la = log2_fixed(64'(cfg_rscale) + 64'(rad));
      lb = log2_fixed(64'(rad));
      d = (la > lb) ? la - lb : 64'd0;
      lq = (d >> 32) * 64'(LN2_Q32) + ((64'(d[31:0]) * 64'(LN2_Q32)) >> 32);
      if (lq == 0 || cfg_alpha == 0) begin
         res.temp = '1;
         res.invalid = 1'b1;
         return res;
      end
      t = capped_quotient(64'(cfg_tscale), T_SHIFT, lq);
      u = longint'(t) - longint'(cfg_beta);
      if (u < 0) begin
         res.invalid = 1'b1;
         return res;
      end
      q = capped_quotient(64'(u), A_SHIFT, 64'(cfg_alpha));
      if (q > 64'hFFFF) begin
         res.temp = '1;
         res.invalid = 1'b1;
      end else begin
         res.temp = q[OUT_W-1:0];
      end
      return res;
   endfunction

   // ---------------------------------------------------------- receive side
   // The long hold-off runs here, counted in cycles, apart from the stimulus.
   always begin
      wait (stall_cycles > 0);
      repeat (stall_cycles) @(posedge clock);
      stall_cycles = 0;
   end

   always @(posedge clock) begin
      rsp_ready <= (stall_cycles == 0) && ($urandom_range(99) >= recv_idle_pct);
   end

   // Inputs only move at rising edges, so the falling edge sees the values
   // that the next rising edge will act on.
   always @(negedge clock) begin
      pixel_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (pending_temps.size() == 0) begin
            if (mismatches < 10)
               $display("unexpected result beat: temp=%h", rsp_temperature_kelvin);
            mismatches++;
         end else begin
            want = pending_temps.pop_front();
            if (rsp_temperature_kelvin !== want.temp || rsp_is_invalid !== want.invalid ||
                rsp_is_nodata !== want.nodata) begin
               if (mismatches < 10)
                  $display("mismatch: expected temp=%h inv=%b nd=%b, got temp=%h inv=%b nd=%b",
                           want.temp, want.invalid, want.nodata, rsp_temperature_kelvin,
                           rsp_is_invalid, rsp_is_nodata);
               mismatches++;
            end
         end
      end
   end

   // ------------------------------------------------------------ send side
   task automatic send_pixel(logic [COUNT_BITS-1:0] cnt);
      logic taken;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_raw_count <= cnt;
      do begin
         @(negedge clock);
         taken = req_ready;
         @(posedge clock);
      end while (!taken);
      pending_temps.insert(pending_temps.size(), brightness_temp(cnt));
      pixels_sent++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_temps.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CSR_CALIB_OFFSET:   cfg_offset = value[CALIB_W-1:0];
         CSR_CALIB_SLOPE:    cfg_slope = value[CALIB_W-1:0];
         CSR_RADIANCE_SCALE: cfg_rscale = value[RSCALE_W-1:0];
         CSR_TEMP_SCALE:     cfg_tscale = value[TS_W-1:0];
         CSR_BAND_ALPHA:     cfg_alpha = value[ALPHA_W-1:0];
         CSR_BAND_BETA:      cfg_beta = value[BETA_W-1:0];
         CSR_NODATA_COUNT:   cfg_nodata_count = value[NODATA_W-1:0];
         CSR_NODATA_OUT:     cfg_nodata_out = value[OUT_W-1:0];
         default: ;
      endcase
   endtask

   // A setting that lands near room temperature: radiance about 1.0,
   // ln(x + 1) about 4.6 and temp_scale about 1400 K.
   task automatic load_plausible_setting();
      write_reg(CSR_CALIB_OFFSET, 63'(32'h0001_0000));
      write_reg(CSR_CALIB_SLOPE, 63'(32'h0000_0040));
      write_reg(CSR_RADIANCE_SCALE, 63'(100) << 16);
      write_reg(CSR_TEMP_SCALE, 63'(1400) << 16);
      write_reg(CSR_BAND_ALPHA, 63'(32'h4000_0000));
      write_reg(CSR_BAND_BETA, 63'(32'h0100_0000));
      write_reg(CSR_NODATA_COUNT, 63'(1024));
      write_reg(CSR_NODATA_OUT, 63'(0));
   endtask

   task automatic load_random_setting();
      if ($urandom_range(9) < 7) begin
         write_reg(CSR_CALIB_OFFSET, 63'($urandom_range(32'h0010_0000, 0)));
         write_reg(CSR_CALIB_SLOPE, 63'(32'($signed($urandom_range(8192)) - 1024)));
         write_reg(CSR_RADIANCE_SCALE, 63'($urandom_range(32'h4000_0000, 1)) << $urandom_range(8));
         write_reg(CSR_TEMP_SCALE, 63'($urandom_range(32'h0800_0000, 32'h0100_0000)));
         write_reg(CSR_BAND_ALPHA, 63'($urandom_range(32'h4800_0000, 32'h3800_0000)));
         write_reg(CSR_BAND_BETA, 63'(32'($signed($urandom_range(32'h0400_0000)) - 32'sh0200_0000)));
      end else begin
         write_reg(CSR_CALIB_OFFSET, 63'($urandom));
         write_reg(CSR_CALIB_SLOPE, 63'($urandom));
         write_reg(CSR_RADIANCE_SCALE, 63'({$urandom, $urandom}));
         write_reg(CSR_TEMP_SCALE, 63'({$urandom, $urandom}));
         write_reg(CSR_BAND_ALPHA, 63'($urandom_range(32'hFFFF_FFFF, 1)));
         write_reg(CSR_BAND_BETA, 63'($urandom));
      end
      write_reg(CSR_NODATA_COUNT, 63'($urandom_range(1024)));
      write_reg(CSR_NODATA_OUT, 63'($urandom_range(16'hFFFF)));
   endtask

   task automatic send_random_pixels(int n);
      for (int i = 0; i < n; i++) begin
         if (i % 100 == 0) begin
            drain_results();
            load_random_setting();
         end
         if ($urandom_range(15) == 0 && cfg_nodata_count < 1024)
            send_pixel(cfg_nodata_count[COUNT_BITS-1:0]);
         else
            send_pixel(COUNT_BITS'($urandom));
      end
      drain_results();
   endtask

   // ---------------------------------------------------------------- tests
   task automatic test_reset_values();
      // After reset the slope and offset are zero, so radiance is not positive.
      send_pixel('0);
      send_pixel('1);
      drain_results();
   endtask

   task automatic test_corner_cases();
      load_plausible_setting();
      send_pixel('0);
      send_pixel('1);
      send_pixel(10'd512);
      drain_results();
      // No-data matches at both ends of the count range.
      write_reg(CSR_NODATA_OUT, 63'(16'hFFFF));
      write_reg(CSR_NODATA_COUNT, 63'(0));
      send_pixel('0);
      send_pixel(10'd1);
      drain_results();
      write_reg(CSR_NODATA_COUNT, 63'(1023));
      write_reg(CSR_NODATA_OUT, 63'(16'hABCD));
      send_pixel('1);
      drain_results();
      write_reg(CSR_NODATA_COUNT, 63'(1024));
      // Negative slope drives radiance below zero for large counts.
      write_reg(CSR_CALIB_SLOPE, 63'(32'h8000_0000));
      send_pixel('1);
      drain_results();
      write_reg(CSR_CALIB_SLOPE, 63'(32'h7FFF_FFFF));
      write_reg(CSR_CALIB_OFFSET, 63'(32'h8000_0000));
      send_pixel('0);
      send_pixel('1);
      drain_results();
      // A zero radiance scale gives a zero logarithm.
      write_reg(CSR_CALIB_OFFSET, 63'(32'h7FFF_FFFF));
      write_reg(CSR_RADIANCE_SCALE, 63'(0));
      send_pixel('0);
      drain_results();
      write_reg(CSR_RADIANCE_SCALE, '1);
      write_reg(CSR_TEMP_SCALE, 63'(40'hFF_FFFF_FFFF));
      send_pixel('0);
      send_pixel('1);
      drain_results();
      // A tiny alpha overflows the result; then the largest alpha is tried with extreme betas.
      load_plausible_setting();
      write_reg(CSR_BAND_ALPHA, 63'(1));
      send_pixel(10'd100);
      drain_results();
      write_reg(CSR_BAND_ALPHA, 63'(32'hFFFF_FFFF));
      write_reg(CSR_BAND_BETA, 63'(32'h7FFF_FFFF));
      send_pixel(10'd100);
      drain_results();
      write_reg(CSR_BAND_BETA, 63'(32'h8000_0000));
      send_pixel(10'd100);
      drain_results();
      write_reg(CSR_TEMP_SCALE, 63'(0));
      send_pixel(10'd100);
      drain_results();
   endtask

   task automatic test_random_idling();
      send_idle_pct = 37;
      recv_idle_pct = 60;
      send_random_pixels(500);
      send_idle_pct = 60;
      recv_idle_pct = 37;
      send_random_pixels(500);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_random_pixels(500);
   endtask

   task automatic test_long_stall();
      load_plausible_setting();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      stall_cycles = 400;
      for (int i = 0; i < 300; i++) send_pixel(COUNT_BITS'($urandom));
      // The sender now waits for every outstanding beat before going on.
      drain_results();
      recv_idle_pct = 30;
      for (int i = 0; i < 50; i++) send_pixel(COUNT_BITS'($urandom));
      drain_results();
   endtask

   initial begin
      int guard;
      mismatches = 0;
      pixels_sent = 0;
      results_seen = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      stall_cycles = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_raw_count = '0;
      rsp_ready = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      cfg_offset = '0;
      cfg_slope = '0;
      cfg_rscale = '0;
      cfg_tscale = '0;
      cfg_alpha = 32'h4000_0000;
      cfg_beta = '0;
      cfg_nodata_count = 11'd1024;
      cfg_nodata_out = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_values();
      test_corner_cases();
      test_random_idling();
      test_long_stall();

      req_valid <= 1'b0;
      guard = 0;
      while (pending_temps.size() != 0 && guard < 100000) begin
         @(posedge clock);
         guard++;
      end
      repeat (LOG_ITERATIONS + 120) @(posedge clock);
      $display("Sent %0d pixels and checked %0d results over random and edge-case settings,",
               pixels_sent, results_seen);
      $display("with idling on both sides and a long output stall; %0d mismatches.",
               mismatches + pending_temps.size());
      if (mismatches == 0 && pending_temps.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

[filelist.f]
hw/rtl/rbt_pkg.sv
hw/rtl/rbt_log2.sv
hw/rtl/radiance_to_brightness_temp.sv
hw/rtl/rbt_checker.sv
bench/tb_radiance_to_brightness_temp.sv
